FILE: rtl/tcvi_pkg.sv
package tcvi_pkg;

  localparam int ACC_W   = 48;
  localparam int LIN_W   = 32;
  localparam int PITCH_W = 17;
  localparam int DT_W    = 16;
  localparam int GRAV_W  = 20;
  localparam int CW      = 34;
  localparam int STEP_W  = 5;
  localparam int SC_W    = 32;
  localparam int OP_W    = 33;
  localparam int PROD_W  = 64;
  localparam int SUM_W   = 65;
  localparam int RND_W   = SUM_W - 30;
  localparam int INC_W   = 33;

  localparam logic [GRAV_W-1:0]         GRAVITY_RESET = 20'd642690;
  localparam logic signed [CW-1:0]      CORDIC_GAIN   = 34'sd652032874;
  localparam logic signed [PITCH_W:0]   HALF_PI       = 18'sd25736;
  localparam logic signed [PITCH_W:0]   PI            = 18'sd51472;

  typedef enum logic [2:0] {
    MUL_YC,
    MUL_ZS,
    MUL_YS,
    MUL_ZC,
    MUL_XD,
    MUL_LYD,
    MUL_LZD
  } mul_sel_t;

  typedef enum logic [1:0] {
    SUM_HOLD,
    SUM_LOAD,
    SUM_ADD,
    SUM_SUB
  } sum_op_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    logic              load;
    logic              cordic_step;
    logic [STEP_W-1:0] step_idx;
    logic              fin;
    logic              mul_en;
    mul_sel_t          mul_sel;
    sum_op_t           sum_op;
    logic              rnd_en;
    logic              ly_en;
    logic              lz_en;
    logic              inc_en;
    logic              acc_en;
    axis_t             acc_axis;
    logic              out_load;
  } dp_cmd_t;

  function automatic logic [31:0] atan_q30(input logic [STEP_W-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'd843314857;
      5'd1:    r = 32'd497837829;
      5'd2:    r = 32'd263043837;
      5'd3:    r = 32'd133525159;
      5'd4:    r = 32'd67021687;
      5'd5:    r = 32'd33543516;
      5'd6:    r = 32'd16775851;
      5'd7:    r = 32'd8388437;
      5'd8:    r = 32'd4194283;
      5'd9:    r = 32'd2097149;
      5'd10:   r = 32'd1048576;
      5'd11:   r = 32'd524288;
      5'd12:   r = 32'd262144;
      5'd13:   r = 32'd131072;
      5'd14:   r = 32'd65536;
      5'd15:   r = 32'd32768;
      5'd16:   r = 32'd16384;
      5'd17:   r = 32'd8192;
      5'd18:   r = 32'd4096;
      5'd19:   r = 32'd2048;
      5'd20:   r = 32'd1024;
      5'd21:   r = 32'd512;
      5'd22:   r = 32'd256;
      5'd23:   r = 32'd128;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/tcvi_ctrl.sv
module tcvi_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tcvi_pkg::dp_cmd_t cmd
);

  localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CORDIC,
    S_FIN,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_M6,
    S_M7,
    S_M8,
    S_M9,
    S_DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd          = '0;
    cmd.step_idx = tcvi_pkg::STEP_W'(cnt);
    case (state)
      S_IDLE:   cmd.load = in_valid && !rst;
      S_CORDIC: cmd.cordic_step = 1'b1;
      S_FIN:    cmd.fin = 1'b1;
      S_M0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tcvi_pkg::MUL_YC;
      end
      S_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tcvi_pkg::MUL_ZS;
        cmd.sum_op  = tcvi_pkg::SUM_LOAD;
      end
      S_M2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tcvi_pkg::MUL_YS;
        cmd.sum_op  = tcvi_pkg::SUM_SUB;
      end
      S_M3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tcvi_pkg::MUL_ZC;
        cmd.sum_op  = tcvi_pkg::SUM_LOAD;
        cmd.rnd_en  = 1'b1;
      end
      S_M4: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tcvi_pkg::MUL_XD;
        cmd.sum_op  = tcvi_pkg::SUM_ADD;
        cmd.ly_en   = 1'b1;
      end
      S_M5: begin
        cmd.rnd_en = 1'b1;
        cmd.inc_en = 1'b1;
      end
      S_M6: begin
        cmd.lz_en    = 1'b1;
        cmd.acc_en   = 1'b1;
        cmd.acc_axis = tcvi_pkg::AXIS_X;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = tcvi_pkg::MUL_LYD;
      end
      S_M7: begin
        cmd.inc_en  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tcvi_pkg::MUL_LZD;
      end
      S_M8: begin
        cmd.acc_en   = 1'b1;
        cmd.acc_axis = tcvi_pkg::AXIS_Y;
        cmd.inc_en   = 1'b1;
      end
      S_M9: begin
        cmd.acc_en   = 1'b1;
        cmd.acc_axis = tcvi_pkg::AXIS_Z;
      end
      S_DONE:   cmd.out_load = !out_valid || out_ready;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CORDIC;
            cnt   <= '0;
          end
        end
        S_CORDIC: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_STEP) begin
            state <= S_FIN;
          end
        end
        S_FIN: state <= S_M0;
        S_M0:  state <= S_M1;
        S_M1:  state <= S_M2;
        S_M2:  state <= S_M3;
        S_M3:  state <= S_M4;
        S_M4:  state <= S_M5;
        S_M5:  state <= S_M6;
        S_M6:  state <= S_M7;
        S_M7:  state <= S_M8;
        S_M8:  state <= S_M9;
        S_M9:  state <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten before transaction");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CORDIC && cnt == '0))
    else $error("accepted transaction did not start rotation");

  a_rot_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_CORDIC && cnt == LAST_STEP) |=> (state == S_FIN))
    else $error("rotation did not end after last step");

  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result presented outside completion");

endmodule

FILE: rtl/tcvi_dp.sv
module tcvi_dp (
  input  logic                                      clk,
  input  logic                                      rst,
  input  tcvi_pkg::dp_cmd_t                         cmd,
  input  logic                                      cfg_we,
  input  logic [tcvi_pkg::GRAV_W-1:0]               cfg_wdata,
  input  logic signed [tcvi_pkg::LIN_W-1:0]         accel_x,
  input  logic signed [tcvi_pkg::LIN_W-1:0]         accel_y,
  input  logic signed [tcvi_pkg::LIN_W-1:0]         accel_z,
  input  logic signed [tcvi_pkg::PITCH_W-1:0]       pitch,
  input  logic [tcvi_pkg::DT_W-1:0]                 dt,
  output logic signed [tcvi_pkg::ACC_W-1:0]         vel_x,
  output logic signed [tcvi_pkg::ACC_W-1:0]         vel_y,
  output logic signed [tcvi_pkg::ACC_W-1:0]         vel_z,
  output logic signed [tcvi_pkg::LIN_W-1:0]         lin_acc_y,
  output logic signed [tcvi_pkg::LIN_W-1:0]         lin_acc_z,
  output logic                                      saturated
);

  localparam int CW     = tcvi_pkg::CW;
  localparam int LIN_W  = tcvi_pkg::LIN_W;
  localparam int ACC_W  = tcvi_pkg::ACC_W;
  localparam int OP_W   = tcvi_pkg::OP_W;
  localparam int SC_W   = tcvi_pkg::SC_W;
  localparam int PROD_W = tcvi_pkg::PROD_W;
  localparam int SUM_W  = tcvi_pkg::SUM_W;
  localparam int RND_W  = tcvi_pkg::RND_W;
  localparam int INC_W  = tcvi_pkg::INC_W;
  localparam int PW     = tcvi_pkg::PITCH_W;

  logic [tcvi_pkg::GRAV_W-1:0]   gravity;
  logic signed [ACC_W-1:0]       acc_x, acc_y, acc_z;

  logic signed [LIN_W-1:0]       ax, ay, az, ly, lz;
  logic [tcvi_pkg::DT_W-1:0]     dt_r;
  logic                          neg;
  logic signed [CW-1:0]          cx, cy, cz;
  logic signed [SC_W-1:0]        sn, cs;
  logic signed [PROD_W-1:0]      prod;
  logic signed [SUM_W-1:0]       sum;
  logic signed [RND_W-1:0]       rnd;
  logic signed [INC_W-1:0]       inc;
  logic                          sat;

  logic signed [PW:0]            p_ext, p_red;
  logic                          p_neg;
  logic signed [CW-1:0]          dx, dy, at;
  logic signed [CW-1:0]          ys, xs;
  logic signed [OP_W-1:0]        opa, opb;
  logic signed [2*OP_W-1:0]      mul_full;
  logic signed [SUM_W-1:0]       prod_ext, rnd_sum;
  logic signed [RND_W:0]         lz_diff;
  logic                          ly_ovf, lz_ovf;
  logic signed [LIN_W-1:0]       ly_clamp, lz_clamp;
  logic signed [PROD_W-1:0]      inc_sum;
  logic signed [ACC_W-1:0]       acc_sel;
  logic signed [ACC_W:0]         acc_sum;
  logic                          acc_ovf;
  logic signed [ACC_W-1:0]       acc_clamp;

  always_comb begin
    p_ext = {pitch[PW-1], pitch};
    p_red = p_ext;
    p_neg = 1'b0;
    if (p_ext > tcvi_pkg::HALF_PI) begin
      p_red = p_ext - tcvi_pkg::PI;
      p_neg = 1'b1;
    end else if (p_ext < -tcvi_pkg::HALF_PI) begin
      p_red = p_ext + tcvi_pkg::PI;
      p_neg = 1'b1;
    end
  end

  always_comb begin
    dx = cy >>> cmd.step_idx;
    dy = cx >>> cmd.step_idx;
    at = CW'(tcvi_pkg::atan_q30(cmd.step_idx));
    ys = neg ? -cy : cy;
    xs = neg ? -cx : cx;
  end

  always_comb begin
    case (cmd.mul_sel)
      tcvi_pkg::MUL_YC: begin
        opa = {ay[LIN_W-1], ay};
        opb = {cs[SC_W-1], cs};
      end
      tcvi_pkg::MUL_ZS: begin
        opa = {az[LIN_W-1], az};
        opb = {sn[SC_W-1], sn};
      end
      tcvi_pkg::MUL_YS: begin
        opa = {ay[LIN_W-1], ay};
        opb = {sn[SC_W-1], sn};
      end
      tcvi_pkg::MUL_ZC: begin
        opa = {az[LIN_W-1], az};
        opb = {cs[SC_W-1], cs};
      end
      tcvi_pkg::MUL_XD: begin
        opa = {ax[LIN_W-1], ax};
        opb = {{(OP_W-tcvi_pkg::DT_W){1'b0}}, dt_r};
      end
      tcvi_pkg::MUL_LYD: begin
        opa = {ly[LIN_W-1], ly};
        opb = {{(OP_W-tcvi_pkg::DT_W){1'b0}}, dt_r};
      end
      tcvi_pkg::MUL_LZD: begin
        opa = {lz[LIN_W-1], lz};
        opb = {{(OP_W-tcvi_pkg::DT_W){1'b0}}, dt_r};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    mul_full = opa * opb;
  end

  always_comb begin
    prod_ext = {prod[PROD_W-1], prod};
    rnd_sum  = sum + (SUM_W'(1) <<< 29);
    lz_diff  = {rnd[RND_W-1], rnd} - $signed({{(RND_W+1-tcvi_pkg::GRAV_W){1'b0}}, gravity});

    ly_ovf   = !((&rnd[RND_W-1:LIN_W-1]) || !(|rnd[RND_W-1:LIN_W-1]));
    ly_clamp = ly_ovf ? (rnd[RND_W-1] ? {1'b1, {(LIN_W-1){1'b0}}} : {1'b0, {(LIN_W-1){1'b1}}})
                      : rnd[LIN_W-1:0];
    lz_ovf   = !((&lz_diff[RND_W:LIN_W-1]) || !(|lz_diff[RND_W:LIN_W-1]));
    lz_clamp = lz_ovf ? (lz_diff[RND_W] ? {1'b1, {(LIN_W-1){1'b0}}}
                                        : {1'b0, {(LIN_W-1){1'b1}}})
                      : lz_diff[LIN_W-1:0];

    inc_sum  = prod + (PROD_W'(1) <<< 15);

    case (cmd.acc_axis)
      tcvi_pkg::AXIS_X: acc_sel = acc_x;
      tcvi_pkg::AXIS_Y: acc_sel = acc_y;
      tcvi_pkg::AXIS_Z: acc_sel = acc_z;
      default:          acc_sel = acc_x;
    endcase
    acc_sum   = {acc_sel[ACC_W-1], acc_sel} + {{(ACC_W+1-INC_W){inc[INC_W-1]}}, inc};
    acc_ovf   = acc_sum[ACC_W] != acc_sum[ACC_W-1];
    acc_clamp = acc_ovf ? (acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                          : {1'b0, {(ACC_W-1){1'b1}}})
                        : acc_sum[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= tcvi_pkg::GRAVITY_RESET;
      acc_x   <= '0;
      acc_y   <= '0;
      acc_z   <= '0;
    end else begin
      if (cfg_we) begin
        gravity <= cfg_wdata;
      end
      if (cmd.acc_en) begin
        case (cmd.acc_axis)
          tcvi_pkg::AXIS_X: acc_x <= acc_clamp;
          tcvi_pkg::AXIS_Y: acc_y <= acc_clamp;
          tcvi_pkg::AXIS_Z: acc_z <= acc_clamp;
          default:          acc_x <= acc_x;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax   <= accel_x;
      ay   <= accel_y;
      az   <= accel_z;
      dt_r <= dt;
      neg  <= p_neg;
      cx   <= tcvi_pkg::CORDIC_GAIN;
      cy   <= '0;
      cz   <= CW'(p_red) <<< 16;
      sat  <= 1'b0;
    end
    if (cmd.cordic_step) begin
      if (!cz[CW-1]) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - at;
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + at;
      end
    end
    if (cmd.fin) begin
      sn <= ys[SC_W-1:0];
      cs <= xs[SC_W-1:0];
    end
    if (cmd.mul_en) begin
      prod <= mul_full[PROD_W-1:0];
    end
    case (cmd.sum_op)
      tcvi_pkg::SUM_LOAD: sum <= prod_ext;
      tcvi_pkg::SUM_ADD:  sum <= sum + prod_ext;
      tcvi_pkg::SUM_SUB:  sum <= sum - prod_ext;
      default:            sum <= sum;
    endcase
    if (cmd.rnd_en) begin
      rnd <= rnd_sum[SUM_W-1:30];
    end
    if (cmd.ly_en) begin
      ly <= ly_clamp;
    end
    if (cmd.lz_en) begin
      lz <= lz_clamp;
    end
    if (cmd.inc_en) begin
      inc <= inc_sum[INC_W+15:16];
    end
    if ((cmd.ly_en && ly_ovf) || (cmd.lz_en && lz_ovf) || (cmd.acc_en && acc_ovf)) begin
      sat <= 1'b1;
    end
    if (cmd.out_load) begin
      vel_x     <= acc_x;
      vel_y     <= acc_y;
      vel_z     <= acc_z;
      lin_acc_y <= ly;
      lin_acc_z <= lz;
      saturated <= sat;
    end
  end

endmodule

FILE: rtl/tilt_compensated_velocity_integrator_core.sv
// Channel   Dir  Payload
// s_axis    in   tdata: accel_x, accel_y, accel_z, pitch, dt (129 bits, zero padded)
// m_axis    out  tdata: vel_x, vel_y, vel_z, lin_acc_y, lin_acc_z; tuser: saturated
// cfg       in   gravity, unsigned Q4.16, written when cfg_we is high
//
// Each sample is processed by the iterative CORDIC and then by the single shared 33x33
// multiplier, which forms the tilt rotation products and the three dt products in turn.
// s_axis_tready returns in the same cycle that the result is presented; no new sample is
// accepted before then. The result register lets the next sample run while the previous result
// waits; a stalled m_axis holds the next sample in its last step with s_axis_tready low.
// rst is synchronous: velocity accumulators clear to zero, gravity returns to 9.80665, tready is low.
module tilt_compensated_velocity_integrator_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,  // accel_x, accel_y, accel_z, pitch, dt
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [207:0] m_axis_tdata,  // vel_x, vel_y, vel_z, lin_acc_y, lin_acc_z
  output logic [0:0]   m_axis_tuser,  // saturated
  input  logic         cfg_we,
  input  logic [19:0]  cfg_wdata
);

  tcvi_pkg::dp_cmd_t cmd;

  logic signed [tcvi_pkg::ACC_W-1:0] vel_x, vel_y, vel_z;
  logic signed [tcvi_pkg::LIN_W-1:0] lin_acc_y, lin_acc_z;
  logic                              saturated;

  tcvi_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  tcvi_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accel_x   (s_axis_tdata[31:0]),
    .accel_y   (s_axis_tdata[63:32]),
    .accel_z   (s_axis_tdata[95:64]),
    .pitch     (s_axis_tdata[112:96]),
    .dt        (s_axis_tdata[128:113]),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .vel_z     (vel_z),
    .lin_acc_y (lin_acc_y),
    .lin_acc_z (lin_acc_z),
    .saturated (saturated)
  );

  assign m_axis_tdata = {lin_acc_z, lin_acc_y, vel_z, vel_y, vel_x};
  assign m_axis_tuser = saturated;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int     STEPS        = 16;
  localparam longint GRAVITY_INIT = 642690;
  localparam longint GRAVITY_TOP  = 1048575;
  localparam longint QUARTER_TURN = 25736;
  localparam longint HALF_TURN    = 51472;
  localparam longint CORDIC_K     = 652032874;
  localparam longint ROUND30      = 64'sd536870912;
  localparam longint ACC_HI       = 64'sd140737488355327;
  localparam longint ACC_LO       = -64'sd140737488355328;
  localparam longint LIN_HI       = 64'sd2147483647;
  localparam longint LIN_LO       = -64'sd2147483648;
  localparam longint MAX32        = 64'sd2147483647;
  localparam longint MIN32        = -64'sd2147483648;
  localparam int     IDLE_LIMIT   = 3000;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     DRAIN_PAD    = 40;

  typedef struct {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [16:0] pitch;
    logic        [15:0] dt;
  } imu_t;

  typedef struct {
    longint vx;
    longint vy;
    longint vz;
    longint ly;
    longint lz;
    bit     sat;
  } velocity_t;

  logic         clk           = 1'b0;
  logic         rst           = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic [135:0] s_axis_tdata  = '0;  // accel_x, accel_y, accel_z, pitch, dt
  logic         m_axis_tready = 1'b0;
  logic         cfg_we        = 1'b0;
  logic [19:0]  cfg_wdata     = '0;
  wire          s_axis_tready;
  wire          m_axis_tvalid;
  wire  [207:0] m_axis_tdata;        // vel_x, vel_y, vel_z, lin_acc_y, lin_acc_z
  wire  [0:0]   m_axis_tuser;        // saturated

  longint atan_tab [0:23] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  longint    acc_vx   = 0;
  longint    acc_vy   = 0;
  longint    acc_vz   = 0;
  longint    grav_q16 = GRAVITY_INIT;
  velocity_t pending_velocities [$];

  int src_idle_pct    = 14;
  int snk_idle_pct    = 57;
  int samples_sent    = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int gravity_writes  = 0;
  int idle_cycles     = 0;
  int hold_left       = 0;
  bit hold_req        = 1'b0;
  bit hold_ack        = 1'b0;

  always #10 clk = ~clk;

  tilt_compensated_velocity_integrator_core #(
    .CORDIC_STEPS(STEPS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  function automatic longint clip(input longint v, input longint lo, input longint hi,
                                  inout bit flag);
    if (v > hi) begin
      flag = 1'b1;
      return hi;
    end
    if (v < lo) begin
      flag = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic void tilt_sincos(input longint ang, output longint sn,
                                      output longint cs);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit     flip;
    flip = 1'b0;
    x    = CORDIC_K;
    y    = 0;
    if (ang > QUARTER_TURN) begin
      ang  = ang - HALF_TURN;
      flip = 1'b1;
    end else if (ang < -QUARTER_TURN) begin
      ang  = ang + HALF_TURN;
      flip = 1'b1;
    end
    z = ang * 65536;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_tab[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_tab[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    sn = y;
    cs = x;
  endfunction

  function automatic velocity_t predict_velocity(input imu_t smp);
    velocity_t r;
    longint    ax;
    longint    ay;
    longint    az;
    longint    dt;
    longint    sn;
    longint    cs;
    bit        sat;
    ax  = smp.ax;
    ay  = smp.ay;
    az  = smp.az;
    dt  = smp.dt;
    sat = 1'b0;
    tilt_sincos(longint'(smp.pitch), sn, cs);
    r.ly = (ay * cs - az * sn + ROUND30) >>> 30;
    r.lz = ((ay * sn + az * cs + ROUND30) >>> 30) - grav_q16;
    r.ly = clip(r.ly, LIN_LO, LIN_HI, sat);
    r.lz = clip(r.lz, LIN_LO, LIN_HI, sat);
    acc_vx = clip(acc_vx + ((ax * dt + 32768) >>> 16), ACC_LO, ACC_HI, sat);
    acc_vy = clip(acc_vy + ((r.ly * dt + 32768) >>> 16), ACC_LO, ACC_HI, sat);
    acc_vz = clip(acc_vz + ((r.lz * dt + 32768) >>> 16), ACC_LO, ACC_HI, sat);
    r.vx  = acc_vx;
    r.vy  = acc_vy;
    r.vz  = acc_vz;
    r.sat = sat;
    return r;
  endfunction

  function automatic imu_t make_imu(input longint ax, input longint ay, input longint az,
                                    input longint pitch, input longint dt);
    imu_t smp;
    smp.ax    = ax[31:0];
    smp.ay    = ay[31:0];
    smp.az    = az[31:0];
    smp.pitch = pitch[16:0];
    smp.dt    = dt[15:0];
    return smp;
  endfunction

  function automatic longint rand_axis();
    longint v;
    case ($urandom_range(0, 9))
      0:       v = MAX32;
      1:       v = MIN32;
      2, 3, 4: v = longint'($signed($urandom()));
      default: v = longint'($urandom_range(0, 25707600)) - 12853800;
    endcase
    return v;
  endfunction

  function automatic imu_t rand_imu();
    longint pitch;
    longint dt;
    case ($urandom_range(0, 9))
      7:       pitch = longint'($urandom_range(0, 131071)) - 65536;
      8:       pitch = QUARTER_TURN - 3 + longint'($urandom_range(0, 6));
      9:       pitch = -QUARTER_TURN - 3 + longint'($urandom_range(0, 6));
      default: pitch = longint'($urandom_range(0, 102944)) - HALF_TURN;
    endcase
    case ($urandom_range(0, 9))
      0:       dt = 0;
      1:       dt = 65535;
      2, 3:    dt = $urandom_range(0, 65535);
      default: dt = $urandom_range(1, 700);
    endcase
    return make_imu(rand_axis(), rand_axis(), rand_axis(), pitch, dt);
  endfunction

  task automatic send_imu(input imu_t smp);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < src_idle_pct)
      gap++;
    if ($urandom_range(0, 399) < src_idle_pct)
      gap = gap + $urandom_range(1, 45);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, smp.dt, smp.pitch, smp.az, smp.ay, smp.ax};
    do @(posedge clk); while (!s_axis_tready);
    pending_velocities.push_back(predict_velocity(smp));
    samples_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_velocities.size() != 0);
  endtask

  task automatic set_gravity(input longint value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[19:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    grav_q16 = value & 64'hFFFFF;
    gravity_writes++;
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic test_directed();
    send_imu(make_imu(0, 0, 0, 0, 0));
    send_imu(make_imu(MAX32, MAX32, MAX32, 0, 65535));
    send_imu(make_imu(MIN32, MIN32, MIN32, 0, 65535));
    send_imu(make_imu(0, 0, GRAVITY_INIT, 0, 1000));
    send_imu(make_imu(65536, 642690, 642690, QUARTER_TURN, 655));
    send_imu(make_imu(65536, -642690, 642690, QUARTER_TURN + 1, 655));
    send_imu(make_imu(-65536, 642690, -642690, -QUARTER_TURN, 655));
    send_imu(make_imu(-65536, 642690, 642690, -QUARTER_TURN - 1, 655));
    send_imu(make_imu(131072, 327680, 642690, HALF_TURN, 1000));
    send_imu(make_imu(131072, 327680, 642690, -HALF_TURN, 1000));
    send_imu(make_imu(-131072, -327680, 642690, 65535, 1000));
    send_imu(make_imu(-131072, -327680, -642690, -65536, 1000));
    send_imu(make_imu(0, MAX32, MIN32, 12868, 65535));
    send_imu(make_imu(0, MIN32, MAX32, 12868, 65535));
    send_imu(make_imu(0, MAX32, MAX32, 12868, 65535));
    send_imu(make_imu(0, MIN32, MIN32, 12868, 65535));
    send_imu(make_imu(MAX32, MAX32, MAX32, 0, 0));
    send_imu(make_imu(1, -1, 1, -1, 1));
    send_imu(make_imu(MAX32, 0, MIN32, -12868, 65535));
    repeat (4) send_imu(make_imu(MAX32, MAX32, MAX32, QUARTER_TURN, 65535));
    wait_drained();
  endtask

  task automatic test_gravity_extremes();
    set_gravity(0);
    send_imu(make_imu(0, 65536, GRAVITY_INIT, 0, 6554));
    send_imu(make_imu(0, 65536, GRAVITY_INIT, HALF_TURN, 6554));
    wait_drained();
    set_gravity(GRAVITY_TOP);
    send_imu(make_imu(0, 0, MIN32, 0, 65535));
    send_imu(make_imu(0, 0, 0, QUARTER_TURN, 100));
    wait_drained();
  endtask

  task automatic test_random(input int count, input int src_pct, input int snk_pct,
                             input longint gravity);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    set_gravity(gravity);
    repeat (count) send_imu(rand_imu());
    wait_drained();
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_req     = ~hold_req;
    repeat (10) send_imu(rand_imu());
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    velocity_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_velocities.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual vel_x %0d", $time,
                 longint'($signed(m_axis_tdata[47:0])));
      end else begin
        want = pending_velocities.pop_front();
        compare_field("vel_x", want.vx, longint'($signed(m_axis_tdata[47:0])));
        compare_field("vel_y", want.vy, longint'($signed(m_axis_tdata[95:48])));
        compare_field("vel_z", want.vz, longint'($signed(m_axis_tdata[143:96])));
        compare_field("lin_acc_y", want.ly, longint'($signed(m_axis_tdata[175:144])));
        compare_field("lin_acc_z", want.lz, longint'($signed(m_axis_tdata[207:176])));
        compare_field("saturated", longint'(want.sat), longint'(m_axis_tuser[0]));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_gravity_extremes();
    test_random(230, 14, 57, $urandom_range(0, GRAVITY_TOP));
    test_backpressure();
    test_random(230, 57, 14, $urandom_range(0, GRAVITY_TOP));
    test_random(230, 0, 0, GRAVITY_INIT);
    repeat (DRAIN_PAD) @(posedge clk);
    $display("Sent %0d IMU samples: pitch folds, saturating rotations, zero time steps, %0d %s",
             samples_sent, gravity_writes, "gravity settings");
    $display("Checked %0d velocity results under random stalls and one long output hold-off",
             results_checked);
    if (mismatches == 0 && pending_velocities.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
rtl/tcvi_pkg.sv
rtl/tcvi_ctrl.sv
rtl/tcvi_dp.sv
rtl/tilt_compensated_velocity_integrator_core.sv
test/tb_top.sv
